### hw/rtl/aabb_pkg.sv
package aabb_pkg;
  localparam int MaxBodies  = 32;
  localparam int CoordWidth = 24;
  localparam int SizeWidth  = CoordWidth - 1;
  localparam int IdxWidth   = $clog2(MaxBodies);
  localparam int CntWidth   = $clog2(MaxBodies + 1);
  localparam int OutIdxWidth = 5;
  localparam int PenWidth   = 24;
  // Doubled overlap: sizes sum minus twice the distance, signed.
  localparam int DblWidth   = CoordWidth + 3;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic [SizeWidth-1:0] size_x;
    logic [SizeWidth-1:0] size_y;
    logic [SizeWidth-1:0] size_z;
    logic solid;
    logic fixed_body;
  } box_t;

  typedef struct packed {
    logic frame_start;
    box_t box;
  } in_item_t;

  typedef struct packed {
    logic [OutIdxWidth-1:0] first_index;
    logic [OutIdxWidth-1:0] second_index;
    logic [PenWidth-1:0] penetration;
    logic [1:0] axis;
    logic normal_negative;
    logic last;
  } out_item_t;

  // Job handed from the front to the back: the new box and how many stored
  // boxes it is tested against.
  typedef struct packed {
    box_t box;
    logic [IdxWidth-1:0] slot;
    logic [CntWidth-1:0] count;
  } job_t;
endpackage

### hw/rtl/aabb_if.sv
interface aabb_in_if;
  import aabb_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface aabb_out_if;
  import aabb_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/aabb_ram.sv
module aabb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hw/rtl/aabb_front.sv
module aabb_front (
  input  logic clk,
  input  logic rst,
  aabb_in_if.sink in_ch,
  output logic job_valid,
  input  logic job_ready,
  output aabb_pkg::job_t job
);
  import aabb_pkg::*;

  logic [CntWidth-1:0] box_count;
  logic [CntWidth-1:0] base;
  logic full;

  // Two-entry queue towards the back.
  job_t q [2];
  logic [1:0] q_used;
  logic q_rd;
  logic q_wr;
  logic push;

  assign base = in_ch.data.frame_start ? '0 : box_count;
  assign full = (base == CntWidth'(MaxBodies));
  assign in_ch.ready = (q_used != 2'd2);
  // An item arriving on a full store is dropped without a job.
  assign push = in_ch.valid && in_ch.ready && !full;
  assign job_valid = (q_used != 2'd0);
  assign job = q[q_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
      q_used <= '0;
      q_rd <= 1'b0;
      q_wr <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        box_count <= full ? base : base + 1'b1;
      end
      if (push) begin
        q_wr <= ~q_wr;
      end
      if (job_valid && job_ready) begin
        q_rd <= ~q_rd;
      end
      q_used <= q_used + {1'b0, push} - {1'b0, job_valid && job_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[q_wr].box <= in_ch.data.box;
      q[q_wr].slot <= base[IdxWidth-1:0];
      q[q_wr].count <= base;
    end
  end
endmodule

### hw/rtl/aabb_back.sv
module aabb_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  aabb_pkg::job_t job,
  aabb_out_if.source out_ch
);
  import aabb_pkg::*;

  localparam int BoxWidth = $bits(box_t);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state;
  box_t cur;
  logic [IdxWidth-1:0] slot;
  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] rd_idx;
  logic rd_vld;
  logic [IdxWidth-1:0] rd_tag;
  logic rd_end;
  logic [IdxWidth-1:0] rd_addr;
  box_t stored;
  logic wr_en;

  // Found pair held back one step so that the final one can carry last.
  logic pend_vld;
  out_item_t pend;

  logic hit;
  out_item_t cand;
  logic out_free;
  logic send;
  out_item_t send_item;

  assign wr_en = (state == StIdle) && job_valid;
  assign job_ready = (state == StIdle);

  // While the scan is held, the entry on show is read again so it stays put.
  assign rd_addr = (state == StScan && !out_free) ? rd_tag : rd_idx[IdxWidth-1:0];

  aabb_ram #(.Width(BoxWidth), .Depth(MaxBodies)) store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(job.slot),
    .wr_data(job.box),
    .rd_addr(rd_addr),
    .rd_data(stored)
  );

  logic signed [DblWidth-1:0] dbl [3];
  logic signed [CoordWidth-1:0] pa [3];
  logic signed [CoordWidth-1:0] pb [3];
  logic [SizeWidth-1:0] sa [3];
  logic [SizeWidth-1:0] sb [3];
  logic [1:0] ax;
  logic signed [DblWidth-1:0] dmin;
  logic apart;

  always_comb begin
    logic signed [CoordWidth:0] d;
    pa = '{stored.pos_x, stored.pos_y, stored.pos_z};
    pb = '{cur.pos_x, cur.pos_y, cur.pos_z};
    sa = '{stored.size_x, stored.size_y, stored.size_z};
    sb = '{cur.size_x, cur.size_y, cur.size_z};
    apart = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = {pa[k][CoordWidth-1], pa[k]} - {pb[k][CoordWidth-1], pb[k]};
      if (d < 0) d = -d;
      dbl[k] = DblWidth'(sa[k]) + DblWidth'(sb[k]) - (DblWidth'(d) <<< 1);
      if (dbl[k] < 0) apart = 1'b1;
    end
    ax = AxisX;
    dmin = dbl[0];
    if (dbl[1] < dmin) begin
      ax = AxisY;
      dmin = dbl[1];
    end
    if (dbl[2] < dmin) begin
      ax = AxisZ;
      dmin = dbl[2];
    end
    hit = rd_vld && cur.solid && stored.solid && !(cur.fixed_body && stored.fixed_body)
          && !apart;
    cand.first_index = OutIdxWidth'(rd_tag);
    cand.second_index = OutIdxWidth'(slot);
    cand.penetration = PenWidth'(dmin >>> 1);
    cand.axis = ax;
    cand.normal_negative = (pa[ax] > pb[ax]);
    cand.last = 1'b0;
  end

  // Scan advances only when the output register can take a pair.
  assign out_free = !out_ch.valid || out_ch.ready;

  // The held pair goes out when a newer one replaces it or when the scan ends.
  always_comb begin
    send = out_free && pend_vld &&
           ((state == StScan && hit) || (state == StFlush));
    send_item = pend;
    send_item.last = (state == StFlush);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rd_vld <= 1'b0;
      pend_vld <= 1'b0;
      out_ch.valid <= 1'b0;
      rd_idx <= '0;
    end else begin
      if (send) begin
        out_ch.valid <= 1'b1;
        out_ch.data <= send_item;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          rd_vld <= 1'b0;
          if (job_valid) begin
            cur <= job.box;
            slot <= job.slot;
            count <= job.count;
            rd_idx <= '0;
            state <= StScan;
          end
        end
        StScan: begin
          if (out_free) begin
            if (hit) begin
              pend <= cand;
              pend_vld <= 1'b1;
            end
            rd_tag <= rd_idx[IdxWidth-1:0];
            rd_end <= (rd_idx + 1'b1 >= count);
            if (rd_vld && rd_end) begin
              rd_vld <= 1'b0;
              state <= StFlush;
            end else if (rd_idx < count) begin
              rd_vld <= 1'b1;
              rd_idx <= rd_idx + 1'b1;
            end else begin
              state <= StFlush;
            end
          end
        end
        StFlush: begin
          if (out_free) begin
            pend_vld <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

### hw/rtl/aabb_pair_collision_finder_core.sv
// An item's pairs pass through the job queue, the box memory read, the held pair
// register and the output register. The scan reads one stored box per cycle
// unless the result side stalls, over the N boxes already stored (up to 32).
// The next job waits for the flush; a two-entry queue decouples input.
// Reset (rst, synchronous) empties the store count and all queues; box memory
// contents are left as they are and are never used before being written.
module aabb_pair_collision_finder_core (
  input logic clk,
  input logic rst,
  aabb_in_if.sink in_ch,
  aabb_out_if.source out_ch
);
  import aabb_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;

  aabb_front front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  aabb_back back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_ch(out_ch)
  );
endmodule

### hw/rtl/aabb_checker.sv
module aabb_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input aabb_pkg::out_item_t out_data
);
  import aabb_pkg::*;

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.axis == AxisX || out_data.axis == AxisY ||
                   out_data.axis == AxisZ)) else $error("bad axis");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.first_index < out_data.second_index)
    else $error("pair index order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");

  a_same_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last ##1 out_valid |->
      out_data.second_index == $past(out_data.second_index)) else $error("group split");
endmodule

bind aabb_pair_collision_finder_core aabb_checker checker_inst (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
